FILE: hdl/pcmdf_pkg.sv
// ----------------------------------------------------------------------------
// PCM packet deframer package
// Shared types, result codes, register indexes and header constants.
// ----------------------------------------------------------------------------
package pcmdf_pkg;

	localparam int unsigned HDR_LEN = 14;
	localparam int unsigned HDR_IDX_W = $clog2(HDR_LEN);
	localparam int unsigned LEN_W = 16;

	// Header layout: signature in bytes 0..3, little-endian length in 12..13.
	localparam logic [HDR_IDX_W-1:0] HDR_LAST_IDX = HDR_IDX_W'(HDR_LEN - 1);
	localparam logic [HDR_IDX_W-1:0] SIG_LAST_IDX = HDR_IDX_W'(3);
	localparam logic [HDR_IDX_W-1:0] LEN_LO_IDX = HDR_IDX_W'(12);
	localparam logic [31:0] SIG_VALUE = 32'hc0ff_eeee;

	// Result kinds.
	typedef enum logic [1:0] {
		KIND_PAYLOAD = 2'd0,
		KIND_HEADER  = 2'd1,
		KIND_BADSIG  = 2'd2,
		KIND_END     = 2'd3
	} kind_t;

	// Configuration register indexes.
	typedef enum logic [0:0] {
		REG_FORWARD_MODE = 1'b0,
		REG_STOP_ON_ZERO = 1'b1
	} reg_idx_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic  take;        // consume the presented input byte
		logic  emit;        // load a result into the output register
		kind_t emit_kind;
		logic  emit_last;
		logic  burst_clr;   // restart the header replay index
		logic  burst_step;  // advance the header replay index
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic can_push;     // output register free or being drained
		logic in_payload;
		logic hdr_done;     // next byte completes a header
		logic sig_ok;       // signature bytes all matched
		logic len_zero_now; // length is zero, using the incoming last byte
		logic len_zero_q;   // length of the held header is zero
		logic burst_last;   // replay index at the last header byte
	} status_t;

	// Expected signature byte by header position, big-endian.
	function automatic logic [7:0] sig_byte(input logic [1:0] pos);
		logic [7:0] b;
		case (pos)
			2'd0:    b = SIG_VALUE[31:24];
			2'd1:    b = SIG_VALUE[23:16];
			2'd2:    b = SIG_VALUE[15:8];
			default: b = SIG_VALUE[7:0];
		endcase
		return b;
	endfunction

endpackage

FILE: hdl/pcmdf_if.sv
// ----------------------------------------------------------------------------
// PCM packet deframer channels
// Valid/ready channel for input bytes and for result items.
// ----------------------------------------------------------------------------
interface pcmdf_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;

	modport source (output valid, output in_byte, input ready);
	modport sink (input valid, input in_byte, output ready);
endinterface

interface pcmdf_out_if;
	logic       valid;
	logic       ready;
	logic [1:0] kind;
	logic [7:0] out_byte;
	logic       last;

	modport source (output valid, output kind, output out_byte, output last, input ready);
	modport sink (input valid, input kind, input out_byte, input last, output ready);
endinterface

FILE: hdl/pcmdf_datapath.sv
// ----------------------------------------------------------------------------
// PCM packet deframer datapath
// Header store, signature check, payload counter and output register.
// ----------------------------------------------------------------------------
module pcmdf_datapath (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [7:0]       in_byte,
	input  pcmdf_pkg::cmd_t  cmd,
	output pcmdf_pkg::status_t sts,
	input  logic             out_ready,
	output logic             out_valid,
	output logic [1:0]       out_kind,
	output logic [7:0]       out_byte,
	output logic             out_last
);
	import pcmdf_pkg::*;

	logic [7:0]           hdr_store_q [HDR_LEN];
	logic [HDR_IDX_W-1:0] hdr_count_q;
	logic                 sig_ok_q;
	logic                 len_zero_q;
	logic [LEN_W-1:0]     payload_left_q;
	logic                 in_payload_q;
	logic [HDR_IDX_W-1:0] burst_idx_q;
	logic                 out_valid_q;
	logic [1:0]           out_kind_q;
	logic [7:0]           out_byte_q;
	logic                 out_last_q;

	logic                 byte_matches;
	logic                 hdr_done;
	logic [7:0]           emit_byte;

	assign byte_matches = (in_byte == sig_byte(hdr_count_q[1:0]));
	assign hdr_done     = !in_payload_q && (hdr_count_q == HDR_LAST_IDX);

	always_comb begin
		sts.can_push     = !out_valid_q || out_ready;
		sts.in_payload   = in_payload_q;
		sts.hdr_done     = hdr_done;
		sts.sig_ok       = sig_ok_q;
		sts.len_zero_now = (hdr_store_q[LEN_LO_IDX] == 8'd0) && (in_byte == 8'd0);
		sts.len_zero_q   = len_zero_q;
		sts.burst_last   = (burst_idx_q == HDR_LAST_IDX);
	end

	always_comb begin
		case (cmd.emit_kind)
			KIND_PAYLOAD: emit_byte = in_byte;
			KIND_HEADER:  emit_byte = hdr_store_q[burst_idx_q];
			default:      emit_byte = 8'd0;
		endcase
	end

	// Header store has no reset: every entry is written before a replay.
	always_ff @(posedge clk) begin
		if (cmd.take && !in_payload_q) begin
			hdr_store_q[hdr_count_q] <= in_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_count_q    <= '0;
			sig_ok_q       <= 1'b0;
			len_zero_q     <= 1'b0;
			payload_left_q <= '0;
			in_payload_q   <= 1'b0;
		end else if (cmd.take) begin
			if (in_payload_q) begin
				payload_left_q <= payload_left_q - LEN_W'(1);
				if (payload_left_q == LEN_W'(1)) begin
					in_payload_q <= 1'b0;
				end
			end else if (hdr_done) begin
				hdr_count_q <= '0;
				len_zero_q  <= sts.len_zero_now;
				if (sig_ok_q && !sts.len_zero_now) begin
					payload_left_q <= {in_byte, hdr_store_q[LEN_LO_IDX]};
					in_payload_q   <= 1'b1;
				end
			end else begin
				hdr_count_q <= hdr_count_q + HDR_IDX_W'(1);
				if (hdr_count_q == '0) begin
					sig_ok_q <= byte_matches;
				end else if (hdr_count_q <= SIG_LAST_IDX) begin
					sig_ok_q <= sig_ok_q && byte_matches;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			burst_idx_q <= '0;
		end else if (cmd.burst_clr) begin
			burst_idx_q <= '0;
		end else if (cmd.burst_step) begin
			burst_idx_q <= burst_idx_q + HDR_IDX_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_kind_q <= cmd.emit_kind;
			out_byte_q <= emit_byte;
			out_last_q <= cmd.emit_last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_kind  = out_kind_q;
	assign out_byte  = out_byte_q;
	assign out_last  = out_last_q;

endmodule

FILE: hdl/pcmdf_ctrl.sv
// ----------------------------------------------------------------------------
// PCM packet deframer controller
// Sequences byte intake, header replay, end-of-stream and halt.
// ----------------------------------------------------------------------------
module pcmdf_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 forward_mode,
	input  logic                 stop_on_zero_size,
	input  pcmdf_pkg::status_t   sts,
	output pcmdf_pkg::cmd_t      cmd
);
	import pcmdf_pkg::*;

	typedef enum logic [3:0] {
		ST_RUN   = 4'b0001,
		ST_BURST = 4'b0010,
		ST_FINAL = 4'b0100,
		ST_HALT  = 4'b1000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   take;
	logic   stop_after;

	// A halted block keeps accepting bytes and drops them without a result.
	assign stop_after = stop_on_zero_size && sts.len_zero_q;
	assign in_ready   = ((state_q == ST_RUN) && sts.can_push) || (state_q == ST_HALT);
	assign take       = in_ready && in_valid;

	always_comb begin
		state_d        = state_q;
		cmd.take       = 1'b0;
		cmd.emit       = 1'b0;
		cmd.emit_kind  = KIND_PAYLOAD;
		cmd.emit_last  = 1'b1;
		cmd.burst_clr  = 1'b0;
		cmd.burst_step = 1'b0;
		case (state_q)
			ST_RUN: begin
				cmd.take      = take;
				cmd.burst_clr = 1'b1;
				if (take) begin
					if (sts.in_payload) begin
						cmd.emit = 1'b1;
					end else if (sts.hdr_done) begin
						if (!sts.sig_ok) begin
							cmd.emit      = 1'b1;
							cmd.emit_kind = KIND_BADSIG;
							state_d       = ST_HALT;
						end else if (forward_mode) begin
							state_d = ST_BURST;
						end else if (sts.len_zero_now && stop_on_zero_size) begin
							cmd.emit      = 1'b1;
							cmd.emit_kind = KIND_END;
							state_d       = ST_HALT;
						end
					end
				end
			end
			ST_BURST: begin
				if (sts.can_push) begin
					cmd.emit       = 1'b1;
					cmd.emit_kind  = KIND_HEADER;
					cmd.emit_last  = sts.burst_last && !stop_after;
					cmd.burst_step = 1'b1;
					if (sts.burst_last) begin
						state_d = stop_after ? ST_FINAL : ST_RUN;
					end
				end
			end
			ST_FINAL: begin
				if (sts.can_push) begin
					cmd.emit      = 1'b1;
					cmd.emit_kind = KIND_END;
					state_d       = ST_HALT;
				end
			end
			ST_HALT: begin
				state_d = ST_HALT;
			end
			default: begin
				state_d = ST_HALT;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_RUN;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

FILE: hdl/pcm_packet_deframer.sv
// ----------------------------------------------------------------------------
// PCM packet deframer top level
// Splits a byte stream of signed packets into payload bytes and results.
// ----------------------------------------------------------------------------
// Payload, error and unforwarded end beats enter the output register as
// their byte is taken; replay beats go via ST_BURST, a later end via ST_FINAL.
// Throughput: one input beat per cycle while tx takes results; a forwarded
// header holds rx during its 14-byte replay and any trailing end beat.
// When halted, rx accepts and discards every beat.
// Reset: arst_n clears control state and configuration, not the header store.
// ----------------------------------------------------------------------------
module pcm_packet_deframer (
	input  logic          clk,
	input  logic          arst_n,
	pcmdf_in_if.sink      rx,
	pcmdf_out_if.source   tx,
	input  logic          cfg_we,
	input  logic [0:0]    cfg_index,
	input  logic [0:0]    cfg_wdata
);
	import pcmdf_pkg::*;

	// Config registers: user must write only while the block is idle; unchecked.
	logic forward_mode_q;
	logic stop_on_zero_size_q;

	cmd_t    cmd;
	status_t sts;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			forward_mode_q      <= 1'b0;
			stop_on_zero_size_q <= 1'b0;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_FORWARD_MODE: forward_mode_q      <= cfg_wdata[0];
				REG_STOP_ON_ZERO: stop_on_zero_size_q <= cfg_wdata[0];
				default: begin
				end
			endcase
		end
	end

	// The controller decides what each beat does. While running it accepts a
	// byte only when the output register can take a result; once halted it
	// accepts every byte and drops it.
	pcmdf_ctrl u_ctrl (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (rx.valid),
		.in_ready          (rx.ready),
		.forward_mode      (forward_mode_q),
		.stop_on_zero_size (stop_on_zero_size_q),
		.sts               (sts),
		.cmd               (cmd)
	);

	// The datapath collects the header, checks the signature as its first
	// four bytes arrive, counts payload bytes and holds the output register.
	pcmdf_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_byte   (rx.in_byte),
		.cmd       (cmd),
		.sts       (sts),
		.out_ready (tx.ready),
		.out_valid (tx.valid),
		.out_kind  (tx.kind),
		.out_byte  (tx.out_byte),
		.out_last  (tx.last)
	);

endmodule

FILE: tb/pcm_packet_deframer_tb.sv
// ----------------------------------------------------------------------------
// PCM packet deframer testbench
// Feeds packet byte streams under random valid/ready idling, predicts every
// result beat with an independent deframer model and compares each beat
// field by field; register settings change between drained phases.
// ----------------------------------------------------------------------------
module pcm_packet_deframer_tb;
	import pcmdf_pkg::*;

	// Quiet cycles allowed before the run is declared hung. The longest legal
	// quiet stretch is a settle pause or an idle burst, far below this.
	localparam int unsigned HANG_LIMIT = 1000;
	// Cycles to let pass after the last expected beat before a register
	// write or the end of the run: a full header replay plus margin.
	localparam int unsigned SETTLE_CYCLES = 24;
	// Mismatch lines printed before further ones are only counted.
	localparam int unsigned PRINT_CAP = 40;

	typedef struct {
		kind_t      kind;
		logic [7:0] data;
		logic       last;
	} deframe_result_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	reg_idx_t cfg_index;
	logic [0:0] cfg_wdata;

	pcmdf_in_if  byte_in ();
	pcmdf_out_if result_out ();

	pcm_packet_deframer DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.rx        (byte_in),
		.tx        (result_out),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Bytes waiting to be offered on the input channel, and the result beats
	// the deframer model says must come out, oldest first.
	logic [7:0]      pending_bytes[$];
	deframe_result_t expected_results[$];

	// Deframer model state, mirrored from the block's behavior.
	logic [7:0]  hdr_bytes [HDR_LEN];
	int unsigned hdr_fill;
	logic [15:0] payload_left;
	logic        in_payload;
	logic        halted;
	logic        forward_on;
	logic        stop_on_zero;

	// Random idling is switched off for the closing part of the run.
	logic        idling_on;
	int unsigned send_gap;
	int unsigned stall_gap;
	int unsigned quiet_cycles;
	int unsigned mismatch_count;

	task automatic report_mismatch(input string msg);
		if (mismatch_count < PRINT_CAP)
			$display("[%0t] mismatch: %s", $realtime, msg);
		mismatch_count++;
	endtask

	// Model of one accepted input byte. Header bytes collect silently until
	// the fourteenth; then the signature decides between an error beat and
	// an optional header replay, and the length field decides what follows.
	task automatic deframe_byte(input logic [7:0] b);
		deframe_result_t beats[$];
		deframe_result_t r;
		logic [15:0] len;
		if (!halted) begin
			if (in_payload) begin
				r.kind = KIND_PAYLOAD;
				r.data = b;
				beats.push_back(r);
				payload_left = payload_left - 16'd1;
				if (payload_left == 16'd0)
					in_payload = 1'b0;
			end else begin
				hdr_bytes[hdr_fill] = b;
				hdr_fill++;
				if (hdr_fill == HDR_LEN) begin
					hdr_fill = 0;
					if ({hdr_bytes[0], hdr_bytes[1], hdr_bytes[2], hdr_bytes[3]} != SIG_VALUE) begin
						r.kind = KIND_BADSIG;
						r.data = 8'h00;
						beats.push_back(r);
						halted = 1'b1;
					end else begin
						len = {hdr_bytes[13], hdr_bytes[12]};
						if (forward_on) begin
							for (int i = 0; i < HDR_LEN; i++) begin
								r.kind = KIND_HEADER;
								r.data = hdr_bytes[i];
								beats.push_back(r);
							end
						end
						if (len == 16'd0) begin
							if (stop_on_zero) begin
								r.kind = KIND_END;
								r.data = 8'h00;
								beats.push_back(r);
								halted = 1'b1;
							end
						end else begin
							payload_left = len;
							in_payload = 1'b1;
						end
					end
				end
			end
		end
		foreach (beats[i]) begin
			r = beats[i];
			r.last = (i == beats.size() - 1);
			expected_results.push_back(r);
		end
	endtask

	// Input driver: offers queued bytes, holds a byte until it is taken and
	// inserts random idle bursts between beats.
	always @(posedge clk) begin
		if (!arst_n) begin
			byte_in.valid <= 1'b0;
			send_gap <= 0;
		end else begin
			if (byte_in.valid && byte_in.ready)
				deframe_byte(byte_in.in_byte);
			if (!byte_in.valid || byte_in.ready) begin
				if (send_gap != 0) begin
					send_gap <= send_gap - 1;
					byte_in.valid <= 1'b0;
				end else if (idling_on && pending_bytes.size() != 0
						&& $urandom_range(0, 5) == 0) begin
					send_gap <= $urandom_range(0, 7);
					byte_in.valid <= 1'b0;
				end else if (pending_bytes.size() != 0) begin
					byte_in.valid <= 1'b1;
					byte_in.in_byte <= pending_bytes.pop_front();
				end else begin
					byte_in.valid <= 1'b0;
				end
			end
		end
	end

	// Output monitor: checks each accepted result beat against the oldest
	// expectation and stalls ready in random bursts.
	always @(posedge clk) begin
		deframe_result_t want;
		if (!arst_n) begin
			result_out.ready <= 1'b0;
			stall_gap <= 0;
		end else begin
			if (result_out.valid && result_out.ready) begin
				if (expected_results.size() == 0) begin
					report_mismatch($sformatf("unexpected beat kind=%0d byte=%02h last=%0b",
						result_out.kind, result_out.out_byte, result_out.last));
				end else begin
					want = expected_results.pop_front();
					if (result_out.kind !== want.kind)
						report_mismatch($sformatf("kind %0d, expected %s",
							result_out.kind, want.kind.name()));
					if (result_out.out_byte !== want.data)
						report_mismatch($sformatf("byte %02h, expected %02h",
							result_out.out_byte, want.data));
					if (result_out.last !== want.last)
						report_mismatch($sformatf("last %0b, expected %0b",
							result_out.last, want.last));
				end
			end
			if (stall_gap != 0) begin
				stall_gap <= stall_gap - 1;
				result_out.ready <= 1'b0;
			end else if (idling_on && $urandom_range(0, 5) == 0) begin
				stall_gap <= $urandom_range(0, 7);
				result_out.ready <= 1'b0;
			end else begin
				result_out.ready <= 1'b1;
			end
		end
	end

	// Hang detection: any cycle without a beat on either channel counts.
	always @(posedge clk) begin
		if (!arst_n || (byte_in.valid && byte_in.ready)
				|| (result_out.valid && result_out.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= HANG_LIMIT) begin
			$display("[%0t] no beat for %0d cycles", $realtime, quiet_cycles);
			$display("TEST FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Writes both registers; the model takes the new values at the same edge
	// the block does. Only called while the block is drained.
	task automatic configure(input logic fwd, input logic stop);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= REG_FORWARD_MODE;
		cfg_wdata <= fwd;
		@(posedge clk);
		forward_on = fwd;
		cfg_index <= REG_STOP_ON_ZERO;
		cfg_wdata <= stop;
		@(posedge clk);
		stop_on_zero = stop;
		cfg_we <= 1'b0;
	endtask

	// Blocks until every queued byte has been taken and every expected beat
	// has arrived, then lets the block settle.
	task automatic wait_drained();
		while (pending_bytes.size() != 0 || byte_in.valid || expected_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic queue_header(input logic [31:0] sig, input logic [63:0] stamp,
			input logic [15:0] len);
		for (int i = 3; i >= 0; i--)
			pending_bytes.push_back(sig[8*i +: 8]);
		for (int i = 7; i >= 0; i--)
			pending_bytes.push_back(stamp[8*i +: 8]);
		pending_bytes.push_back(len[7:0]);
		pending_bytes.push_back(len[15:8]);
	endtask

	// A well-formed packet with a random timestamp and random payload.
	task automatic queue_packet(input logic [15:0] len);
		queue_header(SIG_VALUE, {$urandom(), $urandom()}, len);
		repeat (len)
			pending_bytes.push_back(8'($urandom_range(0, 255)));
	endtask

	// Short payloads, and zero lengths only when they cannot halt.
	function automatic logic [15:0] pick_length(input logic allow_zero);
		logic [15:0] len;
		if (allow_zero && $urandom_range(0, 3) == 0)
			len = 16'd0;
		else
			len = 16'($urandom_range(1, 6));
		return len;
	endfunction

	initial begin
		logic fwd;
		logic stop;
		logic end_by_zero;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_FORWARD_MODE;
		cfg_wdata = 1'b0;
		byte_in.valid = 1'b0;
		byte_in.in_byte = 8'h00;
		result_out.ready = 1'b0;
		hdr_fill = 0;
		payload_left = 16'd0;
		in_payload = 1'b0;
		halted = 1'b0;
		forward_on = 1'b0;
		stop_on_zero = 1'b0;
		idling_on = 1'b1;
		mismatch_count = 0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part in forward mode. A zero-length packet with an
		// all-zero timestamp replays only its header and the very next byte
		// must start a new header; the second packet carries an all-ones
		// timestamp and payload bytes at both extremes.
		configure(1'b1, 1'b0);
		queue_header(SIG_VALUE, 64'h0, 16'd0);
		queue_header(SIG_VALUE, 64'hffff_ffff_ffff_ffff, 16'd2);
		pending_bytes.push_back(8'h00);
		pending_bytes.push_back(8'hff);
		wait_drained();

		// Random part: every combination of the two registers, each phase a
		// short run of well-formed packets. Each phase ends with the sender
		// held until all results have come back.
		for (int phase = 0; phase < 4; phase++) begin
			fwd = phase[0];
			stop = phase[1];
			configure(fwd, stop);
			repeat (1 + $urandom_range(0, 1))
				queue_packet(pick_length(!stop));
			wait_drained();
		end

		// Closing part without idling. The run can halt only once, so the
		// seed picks the way it ends: a zero-length header with stop-on-zero
		// set, or a signature with one bit wrong. Bytes after the halt must
		// be swallowed with no result.
		idling_on = 1'b0;
		end_by_zero = 1'($urandom_range(0, 1));
		fwd = 1'($urandom_range(0, 1));
		stop = end_by_zero ? 1'b1 : 1'($urandom_range(0, 1));
		configure(fwd, stop);
		queue_packet(16'($urandom_range(1, 4)));
		if (end_by_zero)
			queue_header(SIG_VALUE, {$urandom(), $urandom()}, 16'd0);
		else
			queue_header(SIG_VALUE ^ (32'd1 << $urandom_range(0, 31)),
				{$urandom(), $urandom()}, 16'($urandom_range(0, 65535)));
		repeat (4)
			pending_bytes.push_back(8'($urandom_range(0, 255)));
		wait_drained();

		if (mismatch_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
